@@ hdl/hash_keyed_lru_table_core_assert.svh @@
// Assertion macros used by the table datapath RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef HASH_KEYED_LRU_TABLE_CORE_ASSERT_SVH
`define HASH_KEYED_LRU_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKLT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hklt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HKLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hklt assertion failed");

`endif

@@ hdl/hklt_pkg.sv @@
`default_nettype none
package hklt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_FILLED   = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_GET_HIT  = 3'd4;
  localparam logic [2:0] ST_GET_MISS = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam int          MAX_LEN_W     = 16;
  localparam logic [15:0] MAX_LEN_RESET = 16'd2048;
  localparam int          PADDR_W       = 3;
  localparam logic        REG_MAX_LEN   = 1'b0;

  typedef struct packed {
    logic capture;
    logic clear;
    logic scan_start;
    logic scan_run;
    logic commit;
    logic load_out;
  } hklt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } hklt_stat_t;

endpackage
`default_nettype wire

@@ hdl/hklt_req_if.sv @@
`default_nettype none
interface hklt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] key;
  logic [63:0] payload_ref;
  logic [15:0] item_length;

  modport source (output valid, output op, output key, output payload_ref,
                  output item_length, input ready);
  modport sink (input valid, input op, input key, input payload_ref,
                input item_length, output ready);
endinterface

interface hklt_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] key_echo;
  logic [63:0] payload_out;

  modport source (output valid, output status, output key_echo, output payload_out,
                  input ready);
  modport sink (input valid, input status, input key_echo, input payload_out,
                output ready);
endinterface
`default_nettype wire

@@ hdl/hklt_ctrl.sv @@
`default_nettype none
module hklt_ctrl
  import hklt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic [1:0] req_op,
  output logic            req_ready,
  input  hklt_stat_t      st,
  output hklt_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.capture = 1'b1;
          unique case (req_op) inside
            OP_INSERT, OP_GET: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            OP_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = S_DONE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/hklt_dpath.sv @@
`default_nettype none
`include "hash_keyed_lru_table_core_assert.svh"
module hklt_dpath
  import hklt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  hklt_cmd_t                 cmd,
  output hklt_stat_t                st,
  input  wire logic [1:0]           in_op,
  input  wire logic [31:0]          in_key,
  input  wire logic [63:0]          in_payload,
  input  wire logic [15:0]          in_length,
  input  wire logic [MAX_LEN_W-1:0] max_len,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_status,
  output logic [31:0]               out_key,
  output logic [63:0]               out_payload
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNTW-1:0] FULL = CNTW'(TABLE_ENTRIES);

  logic [31:0] key_mem   [TABLE_ENTRIES];
  logic [63:0] pay_mem   [TABLE_ENTRIES];
  logic [63:0] stamp_mem [TABLE_ENTRIES];

  logic [1:0]  op_q;
  logic [31:0] key_q;
  logic [63:0] pay_q;
  logic [15:0] len_q;

  logic [CNTW-1:0] used;
  logic [63:0]     use_counter;

  logic [CNTW-1:0] rd_idx;
  logic            cmp_valid;
  logic [IDXW-1:0] cmp_idx;
  logic            found;
  logic [IDXW-1:0] hit_idx;
  logic            best_set;
  logic [IDXW-1:0] best_idx;
  logic [63:0]     best_stamp;

  logic [31:0] key_rd;
  logic [63:0] pay_rd;
  logic [63:0] stamp_rd;
  logic [2:0]  res_status;

  logic            issue;
  logic            rd_en;
  logic [IDXW-1:0] raddr;
  logic            key_we;
  logic            stamp_we;
  logic [IDXW-1:0] wr_idx;
  logic            used_inc;
  logic            touch;
  logic [2:0]      commit_status;
  logic [63:0]     stamp_wdata;

  assign issue       = cmd.scan_run && (rd_idx < used);
  assign rd_en       = issue || cmd.commit;
  assign raddr       = cmd.commit ? hit_idx : rd_idx[IDXW-1:0];
  assign stamp_wdata = use_counter + 64'd1;

  assign st.scan_done = (rd_idx == used) && !cmp_valid;
  assign st.out_free  = !out_valid || out_ready;

  always_comb begin
    key_we        = 1'b0;
    stamp_we      = 1'b0;
    wr_idx        = hit_idx;
    used_inc      = 1'b0;
    touch         = 1'b0;
    commit_status = ST_GET_MISS;
    if (cmd.commit) begin
      if (op_q == OP_INSERT) begin
        if (found) begin
          stamp_we      = 1'b1;
          touch         = 1'b1;
          commit_status = ST_HIT;
        end else if (len_q >= max_len) begin
          commit_status = ST_REJECTED;
        end else if (used >= FULL) begin
          key_we        = 1'b1;
          stamp_we      = 1'b1;
          touch         = 1'b1;
          wr_idx        = best_idx;
          commit_status = ST_EVICTED;
        end else begin
          key_we        = 1'b1;
          stamp_we      = 1'b1;
          touch         = 1'b1;
          used_inc      = 1'b1;
          wr_idx        = used[IDXW-1:0];
          commit_status = ST_FILLED;
        end
      end else if (found) begin
        stamp_we      = 1'b1;
        touch         = 1'b1;
        commit_status = ST_GET_HIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
      pay_mem[wr_idx] <= pay_q;
    end
    if (stamp_we) begin
      stamp_mem[wr_idx] <= stamp_wdata;
    end
    if (rd_en) begin
      key_rd   <= key_mem[raddr];
      pay_rd   <= pay_mem[raddr];
      stamp_rd <= stamp_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_op;
      key_q <= in_key;
      pay_q <= in_payload;
      len_q <= in_length;
    end
    if (cmd.clear) begin
      res_status <= ST_CLEARED;
    end else if (cmd.commit) begin
      res_status <= commit_status;
    end
    if (issue) begin
      cmp_idx <= rd_idx[IDXW-1:0];
    end
    if (cmp_valid && !found && (key_rd == key_q)) begin
      hit_idx <= cmp_idx;
    end
    if (cmp_valid && (!best_set || (stamp_rd < best_stamp))) begin
      best_idx   <= cmp_idx;
      best_stamp <= stamp_rd;
    end
    if (cmd.load_out) begin
      out_status  <= res_status;
      out_key     <= key_q;
      out_payload <= (res_status == ST_GET_HIT) ? pay_rd : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      use_counter <= '0;
      rd_idx      <= '0;
      cmp_valid   <= 1'b0;
      found       <= 1'b0;
      best_set    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        used        <= '0;
        use_counter <= '0;
      end else begin
        if (used_inc) begin
          used <= used + CNTW'(1);
        end
        if (touch) begin
          use_counter <= stamp_wdata;
        end
      end
      if (cmd.scan_start) begin
        rd_idx    <= '0;
        cmp_valid <= 1'b0;
        found     <= 1'b0;
        best_set  <= 1'b0;
      end else begin
        cmp_valid <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CNTW'(1);
        end
        if (cmp_valid && (key_rd == key_q)) begin
          found <= 1'b1;
        end
        if (cmp_valid) begin
          best_set <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HKLT_ASSERT_SAME(a_used_bound, 1'b1, used <= FULL)
  `HKLT_ASSERT_NEXT(a_clear_empties, cmd.clear, (used == '0) && (use_counter == '0))
  `HKLT_ASSERT_NEXT(a_fill_grows, used_inc, used == $past(used) + CNTW'(1))
  `HKLT_ASSERT_SAME(a_hit_in_range, cmd.commit && found, CNTW'(hit_idx) < used)
  `HKLT_ASSERT_SAME(a_load_when_free, cmd.load_out, !out_valid || out_ready)

endmodule
`default_nettype wire

@@ hdl/hash_keyed_lru_table_core.sv @@
// Fully associative table of TABLE_ENTRIES entries keyed by a 32-bit hash, with
// least-recently-used replacement driven by a 64-bit use counter.
// The req channel carries one request: op (insert, get, clear), key, payload_ref
// and item_length. The res channel returns one result per insert, get or clear
// request with status, key_echo and payload_out; an unused op code is taken
// and dropped without a result. The user writes max_item_length over the APB port
// at paddr[2] low, only while no request is in flight; the block does not check.
// Insert and get walk the occupied entries through the table memories, one
// entry per cycle, checking the key and tracking the oldest stamp together.
// A taken request is captured; an insert or get then passes through the scan,
// commit and done states, and a clear goes straight to done. The result is
// registered on leaving done, and the next request is taken only once the
// controller is back in idle.
// Reset empties the table, zeroes the use counter and sets max_item_length to
// 2048; the table memories need no clearing pass.
// A held result stays in the output register until res.ready is high; a
// request that has finished its lookup waits for that register to free up.
`default_nettype none
module hash_keyed_lru_table_core
  import hklt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  hklt_req_if.sink                req,
  hklt_res_if.source              res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  hklt_cmd_t              cmd;
  hklt_stat_t             st;
  logic [MAX_LEN_W-1:0]   max_len;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_LEN)) begin
      max_len <= pwdata[MAX_LEN_W-1:0];
    end
  end

  hklt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  hklt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_op       (req.op),
    .in_key      (req.key),
    .in_payload  (req.payload_ref),
    .in_length   (req.item_length),
    .max_len     (max_len),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_status  (res.status),
    .out_key     (res.key_echo),
    .out_payload (res.payload_out)
  );

endmodule
`default_nettype wire
